// ===== rtl/dpsplit_pkg.sv =====
// Package: shared constants and types for the packet splitter.
`timescale 1ns / 1ps
package dpsplit_pkg;

	// Longest delimiter and the width of an index into it
	localparam int MAX_DELIM   = 8;
	localparam int DIDX_W      = (MAX_DELIM > 1) ? $clog2(MAX_DELIM) : 1;
	localparam int DLEN_W      = 4;
	localparam int LEN_W       = 16;
	localparam int CFG_IDX_W   = 8;
	localparam int CFG_DATA_W  = 64;

	localparam logic [LEN_W-1:0] LEN_MAX = {LEN_W{1'b1}};

	typedef logic [7:0] byte_t;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		REG_FIXED_MODE  = 8'd0,
		REG_DELIM_LEN   = 8'd1,
		REG_DELIM_BYTES = 8'd2,
		REG_FIXED_LEN   = 8'd3
	} cfg_reg_t;

	// Per-cell compare control from the top level
	typedef struct packed {
		logic  shift_en;
		logic  active;
		byte_t want;
	} cell_ctrl_t;

endpackage

// ===== rtl/delimiter_or_fixed_packet_splitter_core.sv =====
// Top level: packet splitter with delimiter cell chain, length count and output register.
`timescale 1ns / 1ps
// Cuts a received byte stream into packets, one byte per cycle unless the receiver stalls.
// Input channel s_*: one byte per request in s_tdata[7:0].
// Output channel m_*: each byte passed through, with m_tlast set on the byte
// that ends a packet and the packet length so far (saturating at 65535) in
// m_tdata[23:8].
// Configuration channel cfg_*: register index and 64-bit write data, always
// ready; 0 fixed_mode, 1 delim_len, 2 delim_bytes, 3 fixed_len. Other indexes
// are ignored. Write only while the block is idle.
// Output: a result is registered and appears in the cycle after its byte is accepted.
// Throughput: one byte per cycle unless the receiver stalls; the eight delimiter cells compare the
// incoming byte and the held bytes in the same cycle the byte is accepted.
// Reset: registers return to a single line-feed delimiter in delimiter mode,
// fixed length 1, empty byte line and a zero packet count.
// Stall: while the output register holds a result the receiver has not taken,
// s_tready stays low; it rises in the cycle the receiver takes it.
module delimiter_or_fixed_packet_splitter_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,   // [7:0] data_byte
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [23:0]                         m_tdata,   // [7:0] out_byte, [23:8] packet_len
	output logic                                m_tlast,   // end_of_packet
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [dpsplit_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [dpsplit_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import dpsplit_pkg::*;

	logic                   fixed_mode_q;
	logic [DLEN_W-1:0]      delim_len_q;
	logic [8*MAX_DELIM-1:0] delim_bytes_q;
	logic [LEN_W-1:0]       fixed_len_q;
	logic [LEN_W-1:0]       count_q;

	logic                   accept;
	logic [DLEN_W-1:0]      eff_n;
	logic [LEN_W-1:0]       len;
	logic [LEN_W-1:0]       eff_fixed;
	logic                   eop;
	logic                   all_hit;

	cell_ctrl_t             ctrl   [MAX_DELIM];
	byte_t                  chain  [MAX_DELIM+1];
	logic [MAX_DELIM-1:0]   hits;

	byte_t                  out_byte_q;
	logic                   eop_q;
	logic [LEN_W-1:0]       plen_q;
	logic                   m_tvalid_q;

	// Configuration writes
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fixed_mode_q  <= 1'b0;
			delim_len_q   <= DLEN_W'(1);
			delim_bytes_q <= (8*MAX_DELIM)'(10);
			fixed_len_q   <= LEN_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_FIXED_MODE:  fixed_mode_q  <= cfg_data[0];
				REG_DELIM_LEN:   delim_len_q   <= cfg_data[DLEN_W-1:0];
				REG_DELIM_BYTES: delim_bytes_q <= cfg_data[8*MAX_DELIM-1:0];
				REG_FIXED_LEN:   fixed_len_q   <= cfg_data[LEN_W-1:0];
				default: ;
			endcase
		end
	end

	assign accept = s_tvalid && s_tready;

	// Clamp delimiter length to 1..MAX_DELIM, fixed length to at least 1
	always_comb begin
		if (delim_len_q == '0) begin
			eff_n = DLEN_W'(1);
		end else if (delim_len_q > DLEN_W'(MAX_DELIM)) begin
			eff_n = DLEN_W'(MAX_DELIM);
		end else begin
			eff_n = delim_len_q;
		end
		eff_fixed = (fixed_len_q == '0) ? LEN_W'(1) : fixed_len_q;
	end

	// Saturating length including the incoming byte
	assign len = (count_q == LEN_MAX) ? LEN_MAX : count_q + LEN_W'(1);

	// Cell chain: cell k holds the byte k+1 places back; after the shift it
	// holds the byte that must equal delimiter byte n-1-k
	assign chain[0] = s_tdata;

	for (genvar k = 0; k < MAX_DELIM; k++) begin : g_cell
		logic [DLEN_W-1:0] sel;

		assign sel             = eff_n - DLEN_W'(1) - DLEN_W'(k);
		assign ctrl[k].shift_en = accept;
		assign ctrl[k].active   = (DLEN_W'(k) < eff_n);
		assign ctrl[k].want     = delim_bytes_q[8*sel[DIDX_W-1:0] +: 8];

		dpsplit_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (ctrl[k]),
			.byte_in  (chain[k]),
			.byte_out (chain[k+1]),
			.hit      (hits[k])
		);
	end

	assign all_hit = &hits;

	// End of packet decision
	always_comb begin
		if (fixed_mode_q) begin
			eop = (len >= eff_fixed);
		end else begin
			eop = (len >= LEN_W'(eff_n)) && all_hit;
		end
	end

	// Packet byte count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= eop ? '0 : len;
		end
	end

	// Output register; input waits only while a result is held and stalled
	assign s_tready = !m_tvalid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_byte_q <= s_tdata;
			eop_q      <= eop;
			plen_q     <= len;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {plen_q, out_byte_q};
	assign m_tlast  = eop_q;

	// Count restarts after a packet ends
	a_count_clear: assert property (@(posedge clk) disable iff (!arst_n)
		accept && eop |=> count_q == '0)
		else $error("packet count not cleared after end of packet");

	// Count carries the length when the packet continues
	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		accept && !eop |=> count_q == $past(len))
		else $error("packet count did not advance");

	// A held result is never a zero-length packet
	a_len_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> plen_q != '0)
		else $error("result with zero packet length");

	// A stalled result blocks new input
	a_stall_block: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input accepted over a stalled result");

	// Fixed mode never ends a packet before the fixed length
	a_fixed_len: assert property (@(posedge clk) disable iff (!arst_n)
		accept && fixed_mode_q && len < eff_fixed |-> !eop)
		else $error("fixed packet ended early");

endmodule

// ===== rtl/dpsplit_cell.sv =====
// Cell: one stage of the recent-byte line with its delimiter byte compare.
`timescale 1ns / 1ps
module dpsplit_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  dpsplit_pkg::cell_ctrl_t ctrl,
	input  dpsplit_pkg::byte_t  byte_in,
	output dpsplit_pkg::byte_t  byte_out,
	output logic                hit
);
	import dpsplit_pkg::*;

	byte_t byte_q;

	// Held byte moves one cell along on every accepted byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_q <= '0;
		end else if (ctrl.shift_en) begin
			byte_q <= byte_in;
		end
	end

	// Compare the byte arriving here with this cell's delimiter byte
	assign hit      = !ctrl.active || (byte_in == ctrl.want);
	assign byte_out = byte_q;

endmodule

// ===== sim/tb_top.sv =====
// Testbench for the packet splitter: directed table and random framing traffic.
`timescale 1ns / 1ps
module tb_top;
	import dpsplit_pkg::*;

	typedef logic [LEN_W-1:0] len_t;

	// One framed byte as it leaves the block
	typedef struct packed {
		byte_t data;
		logic  eop;
		len_t  len;
	} frame_t;

	typedef enum logic {ROW_CFG, ROW_BYTE} row_kind_t;

	typedef struct {
		row_kind_t                kind;
		logic [CFG_IDX_W-1:0]     idx;
		logic [CFG_DATA_W-1:0]    val;
		bit                       typed;
		frame_t                   want;
	} stim_row_t;

	localparam int                   N_REGS   = int'(REG_FIXED_LEN) + 1;
	localparam logic [CFG_IDX_W-1:0] REG_NONE = {CFG_IDX_W{1'b1}};

	logic                  clk;
	logic                  arst_n;
	logic                  s_tvalid;
	logic                  s_tready;
	logic [7:0]            s_tdata;
	logic                  m_tvalid;
	logic                  m_tready = 1'b0;
	logic [23:0]           m_tdata;
	logic                  m_tlast;
	logic                  cfg_valid;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// Framing model state and its copy of the registers
	byte_t                 seen_bytes [MAX_DELIM];
	len_t                  pkt_count;
	logic                  mdl_fixed;
	logic [DLEN_W-1:0]     mdl_dlen;
	logic [63:0]           mdl_delim;
	len_t                  mdl_flen;

	frame_t                expected_frames [$];
	stim_row_t             directed_rows [$];
	int                    errors = 0;
	bit                    tx_gaps = 1'b1;
	bit                    rx_stalls = 1'b1;
	int                    rx_hold = 0;

	delimiter_or_fixed_packet_splitter_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial clk = 1'b0;
	always #5 clk = ~clk;

	// Next framed byte: shifts the byte line and decides end of packet
	function automatic frame_t frame_byte(byte_t b);
		int unsigned cnt;
		int unsigned n;
		int unsigned fl;
		bit          hit;
		frame_t      r;
		cnt = pkt_count;
		if (cnt < LEN_MAX)
			cnt++;
		for (int i = MAX_DELIM - 1; i > 0; i--)
			seen_bytes[i] = seen_bytes[i-1];
		seen_bytes[0] = b;
		if (mdl_fixed) begin
			fl  = (mdl_flen == 0) ? 1 : mdl_flen;
			hit = (cnt >= fl);
		end else begin
			n   = (mdl_dlen == 0) ? 1 : (mdl_dlen > MAX_DELIM) ? MAX_DELIM : mdl_dlen;
			hit = (cnt >= n);
			// first delimiter byte lines up with the oldest byte of the window
			for (int i = 0; i < n; i++)
				if (seen_bytes[n-1-i] != mdl_delim[8*i +: 8])
					hit = 1'b0;
		end
		r.data    = b;
		r.eop     = hit;
		r.len     = cnt[LEN_W-1:0];
		pkt_count = hit ? '0 : cnt[LEN_W-1:0];
		return r;
	endfunction

	function automatic void model_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		case (idx)
			REG_FIXED_MODE:  mdl_fixed = val[0];
			REG_DELIM_LEN:   mdl_dlen  = val[DLEN_W-1:0];
			REG_DELIM_BYTES: mdl_delim = val;
			REG_FIXED_LEN:   mdl_flen  = val[LEN_W-1:0];
			default: ;
		endcase
	endfunction

	// Idle cycles before a request: mostly none, a few long
	function automatic int pick_gap();
		int r;
		if (!tx_gaps)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 70)
			return 0;
		if (r < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// Byte from a two-letter alphabet half the time, so partial matches occur
	function automatic byte_t pick_byte(byte_t a, byte_t b);
		case ($urandom_range(0, 3))
			0: return a;
			1: return b;
			default: return byte_t'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic void add_byte(byte_t b, bit typed = 1'b0, logic eop = 1'b0,
			len_t len = '0);
		stim_row_t r;
		r.kind  = ROW_BYTE;
		r.idx   = '0;
		r.val   = {56'd0, b};
		r.typed = typed;
		r.want  = '{data: b, eop: eop, len: len};
		directed_rows.push_back(r);
	endfunction

	function automatic void add_cfg(logic [CFG_IDX_W-1:0] idx, logic [63:0] val);
		stim_row_t r;
		r.kind  = ROW_CFG;
		r.idx   = idx;
		r.val   = val;
		r.typed = 1'b0;
		r.want  = '0;
		directed_rows.push_back(r);
	endfunction

	// One byte request; the expectation is logged when it is accepted
	task automatic send_byte(input byte_t b, input bit typed = 1'b0, input frame_t want = '0);
		frame_t pred;
		int     gap;
		gap = pick_gap();
		cfg_valid <= 1'b0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= b;
		do @(posedge clk); while (!s_tready);
		pred = frame_byte(b);
		expected_frames.push_back(typed ? want : pred);
	endtask

	// Register write request; valid is lowered by the next byte request or drain
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk); while (!cfg_ready);
		model_write(idx, val);
	endtask

	// Wait until every byte has come out and the block is quiet
	task automatic drain();
		s_tvalid  <= 1'b0;
		cfg_valid <= 1'b0;
		while (expected_frames.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// New random settings, then well-formed traffic with some noise
	task automatic random_phase(input int unsigned n_items);
		int unsigned sent;
		int unsigned n;
		int unsigned plen;
		int unsigned r;
		logic [63:0] dbytes;
		logic [3:0]  dlen;
		byte_t       la;
		byte_t       lb;
		drain();
		la   = byte_t'($urandom_range(0, 255));
		lb   = byte_t'($urandom_range(0, 255));
		dlen = 4'($urandom_range(0, 15));
		for (int i = 0; i < 8; i++)
			dbytes[8*i +: 8] = pick_byte(la, lb);
		if ($urandom_range(0, 3) == 0)
			dbytes = {$urandom, $urandom};
		write_reg(REG_FIXED_MODE, {$urandom, $urandom});
		write_reg(REG_DELIM_LEN, {$urandom, $urandom} & ~64'hF | 64'(dlen));
		write_reg(REG_DELIM_BYTES, dbytes);
		r = $urandom_range(0, 9);
		write_reg(REG_FIXED_LEN, {$urandom, 16'($urandom),
			(r == 0) ? 16'($urandom_range(0, 1)) :
			(r == 1) ? 16'($urandom_range(25, 400)) : 16'($urandom_range(2, 24))});
		if ($urandom_range(0, 1))
			write_reg(CFG_IDX_W'($urandom_range(N_REGS, 2**CFG_IDX_W - 1)),
				{$urandom, $urandom});
		tx_gaps   = ($urandom_range(0, 3) != 0);
		rx_stalls = ($urandom_range(0, 3) != 0);
		n    = (dlen == 0) ? 1 : (dlen > MAX_DELIM) ? MAX_DELIM : dlen;
		sent = 0;
		while (sent < n_items) begin
			if (mdl_fixed) begin
				send_byte(pick_byte(la, lb));
				sent++;
			end else begin
				plen = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40)
					: $urandom_range(0, 12);
				repeat (plen) begin
					send_byte(pick_byte(la, lb));
					sent++;
				end
				// full delimiter mostly, else a broken prefix or none
				r = $urandom_range(0, 99);
				plen = (r < 85) ? n : (r < 95) ? $urandom_range(0, n - 1) : 0;
				for (int i = 0; i < plen; i++) begin
					send_byte(dbytes[8*i +: 8]);
					sent++;
				end
			end
		end
	endtask

	// Receiver: random stalls, mostly short
	always @(posedge clk) begin
		if (rx_hold > 0) begin
			rx_hold  = rx_hold - 1;
			m_tready <= 1'b0;
		end else if (rx_stalls && $urandom_range(0, 99) < 25) begin
			rx_hold  = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 40)
				: $urandom_range(1, 3);
			rx_hold  = rx_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Result checker
	always @(posedge clk) begin
		frame_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_frames.size() == 0) begin
				errors++;
				$display("%0t: unexpected result byte %02h eop %0b len %0d",
					$time, m_tdata[7:0], m_tlast, m_tdata[23:8]);
			end else begin
				want = expected_frames.pop_front();
				if (m_tdata[7:0] !== want.data) begin
					errors++;
					$display("%0t: out_byte expected %02h got %02h",
						$time, want.data, m_tdata[7:0]);
				end
				if (m_tlast !== want.eop) begin
					errors++;
					$display("%0t: end_of_packet expected %0b got %0b",
						$time, want.eop, m_tlast);
				end
				if (m_tdata[23:8] !== want.len) begin
					errors++;
					$display("%0t: packet_len expected %0d got %0d",
						$time, want.len, m_tdata[23:8]);
				end
			end
		end
	end

	// Watchdog
	initial begin
		#20_000_000;
		$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		mdl_fixed = 1'b0;
		mdl_dlen  = 4'd1;
		mdl_delim = 64'd10;
		mdl_flen  = 16'd1;
		pkt_count = '0;
		foreach (seen_bytes[i])
			seen_bytes[i] = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Reset delimiter: a single line feed
		add_byte(8'h00, 1, 0, 1);
		add_byte(8'hFF, 1, 0, 2);
		add_byte(8'h0A, 1, 1, 3);
		add_byte(8'h0A, 1, 1, 1);
		// zero delimiter length behaves as one
		add_cfg(REG_DELIM_LEN, 64'd0);
		add_byte(8'h0A, 1, 1, 1);
		// CR LF delimiter
		add_cfg(REG_DELIM_LEN, 64'd2);
		add_cfg(REG_DELIM_BYTES, 64'h0A0D);
		add_byte(8'h0D);
		add_byte(8'h0A, 1, 1, 2);
		add_byte(8'h0D);
		add_byte(8'h0D);
		add_byte(8'h0A, 1, 1, 3);
		// oversized length clamps to eight; no match across a packet boundary
		add_cfg(REG_DELIM_LEN, 64'd15);
		add_cfg(REG_DELIM_BYTES, '1);
		repeat (7) add_byte(8'hFF);
		add_byte(8'hFF, 1, 1, 8);
		add_byte(8'hFF);
		add_byte(8'hFF);
		add_byte(8'hFF, 1, 0, 3);
		// fixed mode, zero length behaves as one, count in progress kept
		add_cfg(REG_FIXED_MODE, '1);
		add_cfg(REG_FIXED_LEN, 64'd0);
		add_byte(8'h5A, 1, 1, 4);
		add_byte(8'hA5, 1, 1, 1);
		// length lowered to the count already reached mid-packet
		add_cfg(REG_FIXED_LEN, 64'hFFFF);
		add_byte(8'h00);
		add_byte(8'h00);
		add_cfg(REG_FIXED_LEN, 64'd2);
		add_byte(8'h00, 1, 1, 3);
		// write beyond the register list is dropped
		add_cfg(REG_NONE, 64'd0);
		add_byte(8'h33);
		add_byte(8'hCC);

		foreach (directed_rows[i]) begin
			if (directed_rows[i].kind == ROW_CFG) begin
				drain();
				write_reg(directed_rows[i].idx, directed_rows[i].val);
			end else begin
				send_byte(directed_rows[i].val[7:0], directed_rows[i].typed,
					directed_rows[i].want);
			end
		end

		repeat (12)
			random_phase(150);

		drain();
		if (expected_frames.size() != 0)
			errors++;
		if (errors == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
